>>> design/lpss_pkg.sv
// Shared types and constants for the LED panel scan mode sequencer.
`timescale 1ns / 1ps
package lpss_pkg;

	localparam int ROWS       = 20;
	localparam int ROW_W      = 5;
	localparam int HANDLE_W   = 8;
	localparam int GLYPH_W    = 8;
	localparam int PERIOD_W   = 16;
	localparam int LONG_W     = 24;
	localparam int SKIP_W     = 16;
	localparam int CFG_W      = 24;
	localparam int REG_IDX_W  = 2;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam logic [REG_IDX_W-1:0] REG_TARGET_PERIOD   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_DURATION  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TRIGGER_TIMEOUT = 2'd2;

	localparam logic [PERIOD_W-1:0] TARGET_PERIOD_RST  = 16'd1000;
	localparam logic [LONG_W-1:0]   ERROR_DURATION_RST = 24'd1000000;
	localparam logic [LONG_W-1:0]   TRIG_TIMEOUT_RST   = 24'd1000000;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_PATTERN  = 2'd1,
		OP_ERROR    = 2'd2,
		OP_ROW_DONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		M_PERSIST = 2'd0,
		M_ONESHOT = 2'd1,
		M_TRIG    = 2'd2,
		M_GATED   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BUSY = 2'd1,
		PH_NEXT = 2'd2,
		PH_PAD  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] target_period;
		logic [LONG_W-1:0]   error_duration;
		logic [LONG_W-1:0]   trigger_timeout;
	} cfg_t;

	typedef struct packed {
		op_t                 opcode;
		logic                trigger_level;
		logic [HANDLE_W-1:0] pattern_handle;
		mode_t               pattern_mode;
		logic [GLYPH_W-1:0]  glyph_slot;
		logic                row_fault;
	} item_t;

	typedef struct packed {
		logic                drive_row;
		logic [ROW_W-1:0]    row_index;
		logic                from_error_glyph;
		logic [HANDLE_W-1:0] shown_handle;
		logic [GLYPH_W-1:0]  shown_glyph;
		logic                panel_dark;
		logic                reload_data;
		logic [SKIP_W-1:0]   skipped_count;
	} result_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		mode_t               mode;
		logic                have_image;
		logic                oneshot_due;
		logic                trig_active;
		logic [ROW_W-1:0]    next_row;
	} snap_t;

	typedef struct packed {
		logic                valid;
		mode_t               mode;
		logic [HANDLE_W-1:0] handle;
	} pend_pat_t;

	typedef struct packed {
		logic               valid;
		logic [GLYPH_W-1:0] slot;
	} pend_err_t;

	typedef struct packed {
		mode_t               live_mode;
		logic [HANDLE_W-1:0] live_handle;
		logic                have_image;
		logic                oneshot_due;
		logic                trig_active;
		logic [ROW_W-1:0]    next_row;
		logic                edge_phase;
		logic [LONG_W-1:0]   wait_cnt;
		phase_t              phase;
		logic [PERIOD_W-1:0] period_cnt;
		logic                err_active;
		logic [LONG_W-1:0]   err_cnt;
		logic [GLYPH_W-1:0]  err_glyph;
		snap_t               snap;
		pend_pat_t           pend_pat;
		pend_err_t           pend_err;
		logic [SKIP_W-1:0]   skip_total;
	} state_t;

endpackage

>>> design/lpss_step.sv
// Next-state and result logic for one word of the scan mode sequencer.
`timescale 1ns / 1ps
module lpss_step (
	input  lpss_pkg::cfg_t    cfg,
	input  lpss_pkg::state_t  st,
	input  lpss_pkg::item_t   item,
	output lpss_pkg::state_t  st_nxt,
	output lpss_pkg::result_t res
);
	import lpss_pkg::*;

	state_t           d;
	logic             drv;
	logic [ROW_W-1:0] idx;
	logic             rld;
	logic             bnd_done;
	logic             fired;
	mode_t            kind;
	logic [ROW_W:0]   nr6;

	always_comb begin
		d        = st;
		drv      = 1'b0;
		idx      = '0;
		rld      = 1'b0;
		bnd_done = 1'b0;
		fired    = 1'b0;
		kind     = st.err_active ? M_PERSIST : st.live_mode;
		nr6      = {1'b0, st.next_row};

		case (item.opcode)
			OP_TICK: begin
				if (d.err_active && d.err_cnt != '0)
					d.err_cnt = d.err_cnt - 1'b1;
				if (d.phase != PH_IDLE && d.period_cnt != '1)
					d.period_cnt = d.period_cnt + 1'b1;
				if (d.phase == PH_PAD && d.period_cnt >= cfg.target_period)
					d.phase = PH_IDLE;

				if (d.phase == PH_IDLE) begin
					// frame boundary
					if (d.err_active) begin
						if (d.err_cnt != '0) begin
							d.next_row   = '0;
							d.period_cnt = '0;
							drv          = 1'b1;
							d.phase      = PH_BUSY;
							bnd_done     = 1'b1;
						end else begin
							// window over: restore or go dark
							d.err_active = 1'b0;
							if (!d.snap.have_image ||
							    (d.snap.mode == M_ONESHOT && !d.snap.oneshot_due)) begin
								d.have_image  = 1'b0;
								d.oneshot_due = 1'b0;
								d.trig_active = 1'b0;
							end else begin
								d.live_handle = d.snap.handle;
								d.live_mode   = d.snap.mode;
								d.have_image  = 1'b1;
								d.oneshot_due = d.snap.oneshot_due;
								d.trig_active = d.snap.trig_active;
								d.next_row    = d.snap.next_row;
								rld           = 1'b1;
							end
						end
					end
					if (!bnd_done && d.pend_err.valid) begin
						d.snap.handle      = d.live_handle;
						d.snap.mode        = d.live_mode;
						d.snap.have_image  = d.have_image;
						d.snap.oneshot_due = d.oneshot_due;
						d.snap.trig_active = d.trig_active;
						d.snap.next_row    = d.next_row;
						d.err_glyph        = d.pend_err.slot;
						d.err_active       = 1'b1;
						d.err_cnt          = cfg.error_duration;
						d.pend_err         = '0;
						d.pend_pat         = '0;
						rld                = 1'b1;
						d.next_row         = '0;
						d.period_cnt       = '0;
						drv                = 1'b1;
						d.phase            = PH_BUSY;
						bnd_done           = 1'b1;
					end
					if (!bnd_done) begin
						if (d.pend_pat.valid) begin
							d.live_handle = d.pend_pat.handle;
							d.live_mode   = d.pend_pat.mode;
							d.pend_pat    = '0;
							d.have_image  = 1'b1;
							d.oneshot_due = (d.live_mode == M_ONESHOT);
							d.trig_active = (d.live_mode == M_TRIG);
							if (d.live_mode == M_TRIG)
								d.next_row = '0;
							rld = 1'b1;
						end
						if (d.have_image) begin
							case (d.live_mode)
								M_PERSIST: begin
									d.next_row   = '0;
									d.period_cnt = '0;
									drv          = 1'b1;
									d.phase      = PH_BUSY;
								end
								M_ONESHOT: begin
									if (d.oneshot_due) begin
										d.oneshot_due = 1'b0;
										d.next_row    = '0;
										d.period_cnt  = '0;
										drv           = 1'b1;
										d.phase       = PH_BUSY;
									end
								end
								M_TRIG: begin
									if (d.trig_active) begin
										if ({1'b0, d.next_row} >= (ROW_W + 1)'(ROWS)) begin
											d.have_image  = 1'b0;
											d.oneshot_due = 1'b0;
											d.trig_active = 1'b0;
											d.next_row    = '0;
										end else begin
											d.phase      = PH_NEXT;
											d.edge_phase = 1'b0;
											d.wait_cnt   = '0;
											d.period_cnt = '0;
										end
									end
								end
								M_GATED: begin
									if (item.trigger_level) begin
										d.next_row   = '0;
										d.period_cnt = '0;
										drv          = 1'b1;
										d.phase      = PH_BUSY;
									end
								end
								default: ;
							endcase
						end
					end
				end else if (d.phase == PH_NEXT) begin
					if (kind == M_TRIG) begin
						if (!d.edge_phase) begin
							if (!item.trigger_level)
								d.edge_phase = 1'b1;
						end else if (item.trigger_level) begin
							fired = 1'b1;
						end
						if (fired) begin
							d.edge_phase = 1'b0;
							d.wait_cnt   = '0;
							drv          = 1'b1;
							idx          = d.next_row;
							d.phase      = PH_BUSY;
						end else begin
							if (d.wait_cnt != '1)
								d.wait_cnt = d.wait_cnt + 1'b1;
							if (d.wait_cnt >= cfg.trigger_timeout) begin
								d.have_image  = 1'b0;
								d.oneshot_due = 1'b0;
								d.trig_active = 1'b0;
								d.next_row    = '0;
								d.phase       = PH_IDLE;
							end
						end
					end else if (kind == M_GATED) begin
						if (item.trigger_level) begin
							drv     = 1'b1;
							idx     = d.next_row;
							d.phase = PH_BUSY;
						end else begin
							d.phase = PH_IDLE;
						end
					end else begin
						drv     = 1'b1;
						idx     = d.next_row;
						d.phase = PH_BUSY;
					end
				end
			end

			OP_PATTERN: begin
				if (!d.err_active) begin
					if (d.pend_pat.valid && d.skip_total != '1)
						d.skip_total = d.skip_total + 1'b1;
					d.pend_pat.valid  = 1'b1;
					d.pend_pat.mode   = item.pattern_mode;
					d.pend_pat.handle = item.pattern_handle;
				end
			end

			OP_ERROR: begin
				if (!d.err_active && !d.pend_err.valid) begin
					d.pend_err.valid = 1'b1;
					d.pend_err.slot  = item.glyph_slot;
				end
			end

			OP_ROW_DONE: begin
				if (d.phase == PH_BUSY) begin
					if (kind == M_TRIG) begin
						if (!item.row_fault)
							nr6 = nr6 + 1'b1;
						if (nr6 >= (ROW_W + 1)'(ROWS)) begin
							d.have_image  = 1'b0;
							d.oneshot_due = 1'b0;
							d.trig_active = 1'b0;
							d.next_row    = '0;
							d.phase       = PH_IDLE;
						end else begin
							d.next_row   = nr6[ROW_W-1:0];
							d.phase      = PH_NEXT;
							d.edge_phase = 1'b0;
							d.wait_cnt   = '0;
						end
					end else if (item.row_fault && kind != M_GATED) begin
						d.phase = PH_IDLE;
					end else begin
						nr6 = nr6 + 1'b1;
						if (nr6 >= (ROW_W + 1)'(ROWS)) begin
							d.next_row = '0;
							d.phase    = (d.period_cnt < cfg.target_period) ? PH_PAD : PH_IDLE;
						end else begin
							d.next_row = nr6[ROW_W-1:0];
							d.phase    = PH_NEXT;
						end
					end
				end
			end

			default: ;
		endcase

		st_nxt = d;

		res.drive_row        = drv;
		res.row_index        = drv ? idx : '0;
		res.from_error_glyph = d.err_active;
		res.shown_handle     = (!d.err_active && d.have_image) ? d.live_handle : '0;
		res.shown_glyph      = d.err_active ? d.err_glyph : '0;
		res.panel_dark       = !d.err_active && !d.have_image;
		res.reload_data      = rld;
		res.skipped_count    = d.skip_total;
	end

endmodule

>>> design/led_panel_scan_mode_sequencer.sv
// Top level of the LED panel scan mode sequencer: handshake, registers, config.
`timescale 1ns / 1ps
// Usage
//   Input channel s_axis_*: one word per event. tuser carries the opcode
//   (tick, pattern arrival, error raise, row done); tdata carries the
//   trigger level, pattern handle and mode, glyph slot and row fault.
//   Output channel m_axis_*: exactly one result word per input word, in
//   order: row drive command, shown image, dark flag, reload flag, skip
//   count. tuser marks that the error glyph is shown.
//   Config port: cfg_we/cfg_index/cfg_data write target_period (0),
//   error_duration (1) and trigger_timeout (2); write only while idle.
// Timing
//   An accepted word is held in the input register, then the sequencer
//   update lands in the output register. Throughput is one word per cycle
//   while the receiver keeps up; a stalled output holds the flow. The
//   whole state is a handful of counters and flags.
// Reset and stall
//   arst_n clears the sequencer state and both valid flags; config registers return to 1000 / 1000000 / 1000000.
//   A stalled receiver holds the output word; the input register still
//   takes one more word, then tready drops until the output drains.
module led_panel_scan_mode_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] trigger_level, [8:1] pattern_handle, [10:9] pattern_mode,
	// [18:11] glyph_slot, [19] row_fault, [23:20] zero
	input  logic [lpss_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] drive_row, [5:1] row_index, [13:6] shown_handle,
	// [21:14] shown_glyph, [22] panel_dark, [23] reload_data,
	// [39:24] skipped_count
	output logic [lpss_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [0] from_error_glyph
	output logic                                m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [lpss_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [lpss_pkg::CFG_W-1:0]          cfg_data
);
	import lpss_pkg::*;

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_nxt;
	item_t   item_s1;
	item_t   item_in;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	// unpack the incoming word
	assign item_in.opcode         = op_t'(s_axis_tuser);
	assign item_in.trigger_level  = s_axis_tdata[0];
	assign item_in.pattern_handle = s_axis_tdata[8:1];
	assign item_in.pattern_mode   = mode_t'(s_axis_tdata[10:9]);
	assign item_in.glyph_slot     = s_axis_tdata[18:11];
	assign item_in.row_fault      = s_axis_tdata[19];

	// the s1 word moves on when the output register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	lpss_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_period   <= TARGET_PERIOD_RST;
			cfg_q.error_duration  <= ERROR_DURATION_RST;
			cfg_q.trigger_timeout <= TRIG_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_PERIOD:   cfg_q.target_period   <= cfg_data[PERIOD_W-1:0];
				REG_ERROR_DURATION:  cfg_q.error_duration  <= cfg_data[LONG_W-1:0];
				REG_TRIGGER_TIMEOUT: cfg_q.trigger_timeout <= cfg_data[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.from_error_glyph;
	assign m_axis_tdata  = {res_q.skipped_count, res_q.reload_data, res_q.panel_dark,
	                        res_q.shown_glyph, res_q.shown_handle, res_q.row_index,
	                        res_q.drive_row};

endmodule

>>> design/lpss_checker.sv
// Port-level checks for the scan mode sequencer, bound to the top level.
`timescale 1ns / 1ps
module lpss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lpss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser
);
	import lpss_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// no row index without a drive command
	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[5:1] == '0)
		else $error("row index set without drive_row");

	// glyph window hides handle and dark flag
	a_glyph_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[13:6] == '0 && !m_axis_tdata[22])
		else $error("handle or dark flag shown during glyph window");

	// glyph slot only inside the window
	a_glyph_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[21:14] == '0)
		else $error("glyph slot shown outside the window");

endmodule

bind led_panel_scan_mode_sequencer lpss_checker u_lpss_checker (.*);
